@@ rtl/core/hough_line_accumulator_top_assert.svh @@
// Assertion macros for the Hough line accumulator.
`ifndef HOUGH_LINE_ACCUMULATOR_TOP_ASSERT_SVH
`define HOUGH_LINE_ACCUMULATOR_TOP_ASSERT_SVH
`ifndef SYNTH
`define HLA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hla check failed");
`define HLA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hla check failed");
`else
`define HLA_ASSERT_IMP(lbl, ante, cons)
`define HLA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ rtl/core/hla_pkg.sv @@
// Shared types, constants and trig table for the Hough line accumulator.
`default_nettype none
package hla_pkg;

  localparam int MAX_DIM        = 512;
  localparam int RHO_BINS       = 2048;
  localparam int THETA_BINS     = 180;
  localparam int COUNT_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 14;

  localparam int ROW_W = 12;  // covers the largest rho row count
  localparam int ANG_W = 9;   // covers the largest angle count

  localparam logic [1:0] REQ_VOTE  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_THRESH = 2'd2;
  localparam logic [1:0] CFG_OFFSET = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VOTE,
    ST_DRAIN,
    ST_READ,
    ST_RESP
  } hla_state_t;

  // Result of the rho stage for one angle.
  typedef struct packed {
    logic             busy;
    logic             vld;
    logic [ROW_W-1:0] row;
    logic [ANG_W-1:0] ang;
  } hla_rho_st_t;

  localparam logic [14:0] SIN_Q14 [0:90] = '{
    15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
    15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
    15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872,
    15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
    15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
    15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749, 15'd10963,
    15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
    15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189,
    15'd14330, 15'd14466, 15'd14598, 15'd14726, 15'd14849, 15'd14968,
    15'd15082, 15'd15191, 15'd15296, 15'd15396, 15'd15491, 15'd15582,
    15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964, 15'd16026,
    15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
    15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  // Signed Q1.14 sine of deg degrees, deg below 360.
  function automatic logic signed [15:0] hla_sin(input logic [ANG_W-1:0] deg);
    logic [ANG_W-1:0] k;
    logic             neg;
    begin
      neg = 1'b0;
      if (deg <= ANG_W'(90)) begin
        k = deg;
      end else if (deg <= ANG_W'(180)) begin
        k = ANG_W'(180) - deg;
      end else if (deg <= ANG_W'(270)) begin
        k = deg - ANG_W'(180);
        neg = 1'b1;
      end else begin
        k = ANG_W'(360) - deg;
        neg = 1'b1;
      end
      hla_sin = neg ? -$signed({1'b0, SIN_Q14[k[6:0]]}) : $signed({1'b0, SIN_Q14[k[6:0]]});
    end
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/hla_if.sv @@
// Valid/ready channel interfaces for request and result words.
`default_nettype none
interface hla_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [8:0] pixel_x;
  logic [8:0] pixel_y;
  logic [7:0] edge_magnitude;
  logic [10:0] rho_index;
  logic [7:0] theta_index;
  modport source (output valid, req_type, pixel_x, pixel_y, edge_magnitude,
                  rho_index, theta_index, input ready);
  modport sink (input valid, req_type, pixel_x, pixel_y, edge_magnitude,
                rho_index, theta_index, output ready);
endinterface

interface hla_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] cell_count;
  logic [15:0] max_count;
  logic        above_half_max;
  modport source (output valid, cell_count, max_count, above_half_max, input ready);
  modport sink (input valid, cell_count, max_count, above_half_max, output ready);
endinterface
`default_nettype wire

@@ rtl/core/hough_line_accumulator_top.sv @@
// Hough line accumulator: vote, read and clear over one counter memory.
//
// Usage:
//   in_ch carries request words (vote, read cell, clear); out_ch returns one
//   result word for each read request. cfg_we/cfg_idx/cfg_wdata write the
//   frame size, edge threshold and rho offset; the user must write them only
//   while the block is idle, which the block itself does not enforce.
// Request handling:
//   A vote above threshold walks all THETA_BINS angles: one angle enters the
//   rho pipeline each cycle, and the single memory port pair does one
//   read-modify-write per angle whose row is in range. Other votes change
//   nothing. A read holds in_ch through ST_READ and ST_RESP, then loads the
//   registered RAM data into the output register. A clear, like reset, zeroes
//   all RHO_BINS * THETA_BINS cells with in_ch.ready low, one zero per cycle.
// Reset:
//   rst_n low restores the register defaults, zeroes the maximum and starts
//   the clearing sweep.
// Back-pressure:
//   A result word waits in an output register while out_ch.ready is low;
//   new requests are still taken, and a later read holds until the slot frees.
`default_nettype none
`include "hough_line_accumulator_top_assert.svh"
module hough_line_accumulator_top #(
  parameter int RHO_BINS   = hla_pkg::RHO_BINS,
  parameter int THETA_BINS = hla_pkg::THETA_BINS,
  parameter int COUNT_BITS = hla_pkg::COUNT_BITS
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  hla_in_if.sink          in_ch,
  hla_out_if.source       out_ch,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_idx,
  input  wire logic [9:0] cfg_wdata
);
  localparam int DEPTH = RHO_BINS * THETA_BINS;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = $clog2(THETA_BINS);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  hla_pkg::hla_state_t state_r, state_nxt;

  // Configuration registers.
  logic [9:0] width_r, height_r, offset_r;
  logic [7:0] thresh_r;

  logic [AW-1:0]          clr_r;
  logic [TW-1:0]          ang_r;
  logic signed [10:0]     dx_r, dy_r;
  logic [COUNT_BITS-1:0]  peak_r;
  logic                   wv_r;
  logic [AW-1:0]          wa_r;
  logic [AW-1:0]          rq_addr_r;
  logic                   rq_ok_r;

  logic                   ov_r;
  logic [15:0]            cell_r, max_r;
  logic                   above_r;

  hla_pkg::hla_rho_st_t   rho_st;
  logic                   acc, iss;
  logic [AW-1:0]          vaddr;
  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_wa, ram_ra;
  logic [COUNT_BITS-1:0]  ram_wd, ram_rd, inc;
  logic [COUNT_BITS-1:0]  cnt;
  logic [COUNT_BITS+15:0] cnt_ext, peak_ext;
  logic                   slot_free;

  assign in_ch.ready = (state_r == hla_pkg::ST_IDLE);
  assign acc         = in_ch.valid && in_ch.ready;
  assign iss         = (state_r == hla_pkg::ST_VOTE);
  assign slot_free   = !ov_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 10'd512;
      height_r <= 10'd512;
      thresh_r <= 8'd220;
      offset_r <= 10'd724;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        hla_pkg::CFG_WIDTH:  width_r  <= cfg_wdata;
        hla_pkg::CFG_HEIGHT: height_r <= cfg_wdata;
        hla_pkg::CFG_THRESH: thresh_r <= cfg_wdata[7:0];
        hla_pkg::CFG_OFFSET: offset_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  hla_rho #(.RHO_BINS(RHO_BINS)) u_rho (
    .clk   (clk),
    .rst_n (rst_n),
    .iss   (iss),
    .ang   (hla_pkg::ANG_W'(ang_r)),
    .dx    (dx_r),
    .dy    (dy_r),
    .ofs   (offset_r),
    .st    (rho_st)
  );

  // Cell address of the angle leaving the rho pipeline.
  assign vaddr = AW'(rho_st.row) * AW'(THETA_BINS) + AW'(rho_st.ang);

  // Saturating increment of the cell just read back.
  assign inc = (ram_rd == CNT_MAX) ? ram_rd : ram_rd + 1'b1;

  always_comb begin
    ram_re = 1'b0;
    ram_ra = vaddr;
    if (state_r == hla_pkg::ST_READ) begin
      ram_re = 1'b1;
      ram_ra = rq_addr_r;
    end else if (rho_st.vld) begin
      ram_re = 1'b1;
    end
    if (state_r == hla_pkg::ST_CLEAR) begin
      ram_we = 1'b1;
      ram_wa = clr_r;
      ram_wd = '0;
    end else begin
      ram_we = wv_r;
      ram_wa = wa_r;
      ram_wd = inc;
    end
  end

  hla_ram #(.W(COUNT_BITS), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (ram_wd),
    .re    (ram_re),
    .raddr (ram_ra),
    .rdata (ram_rd)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hla_pkg::ST_CLEAR: begin
        if (clr_r == AW'(DEPTH - 1)) state_nxt = hla_pkg::ST_IDLE;
      end
      hla_pkg::ST_IDLE: begin
        if (acc) begin
          case (in_ch.req_type)
            hla_pkg::REQ_VOTE: begin
              if (in_ch.edge_magnitude > thresh_r) state_nxt = hla_pkg::ST_VOTE;
            end
            hla_pkg::REQ_READ:  state_nxt = hla_pkg::ST_READ;
            hla_pkg::REQ_CLEAR: state_nxt = hla_pkg::ST_CLEAR;
            default: ;
          endcase
        end
      end
      hla_pkg::ST_VOTE: begin
        if (ang_r == TW'(THETA_BINS - 1)) state_nxt = hla_pkg::ST_DRAIN;
      end
      hla_pkg::ST_DRAIN: begin
        if (!rho_st.busy && !wv_r) state_nxt = hla_pkg::ST_IDLE;
      end
      hla_pkg::ST_READ: state_nxt = hla_pkg::ST_RESP;
      hla_pkg::ST_RESP: begin
        if (slot_free) state_nxt = hla_pkg::ST_IDLE;
      end
      default: state_nxt = hla_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hla_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sweep counter, angle walker, write-back stage and maximum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r  <= '0;
      ang_r  <= '0;
      wv_r   <= 1'b0;
      peak_r <= '0;
    end else begin
      wv_r <= rho_st.vld;
      if (state_r == hla_pkg::ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end else begin
        clr_r <= '0;
      end
      if (iss) begin
        ang_r <= ang_r + 1'b1;
      end else begin
        ang_r <= '0;
      end
      if (acc && in_ch.req_type == hla_pkg::REQ_CLEAR) begin
        peak_r <= '0;
      end else if (wv_r && inc > peak_r) begin
        peak_r <= inc;
      end
    end
  end

  // Request payload: centered coordinates and read address.
  always_ff @(posedge clk) begin
    wa_r <= vaddr;
    if (acc) begin
      dx_r <= $signed({2'b0, in_ch.pixel_x}) - $signed({2'b0, width_r[9:1]});
      dy_r <= $signed({2'b0, in_ch.pixel_y}) - $signed({2'b0, height_r[9:1]});
      rq_addr_r <= AW'(in_ch.rho_index) * AW'(THETA_BINS) + AW'(in_ch.theta_index);
      rq_ok_r   <= (32'(in_ch.rho_index) < 32'(RHO_BINS)) &&
                   (32'(in_ch.theta_index) < 32'(THETA_BINS));
    end
  end

  // Result word: hold until taken.
  assign cnt      = rq_ok_r ? ram_rd : '0;
  assign cnt_ext  = {16'b0, cnt};
  assign peak_ext = {16'b0, peak_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (state_r == hla_pkg::ST_RESP && slot_free) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == hla_pkg::ST_RESP && slot_free) begin
      cell_r  <= cnt_ext[15:0];
      max_r   <= peak_ext[15:0];
      above_r <= (cnt >= (peak_r >> 1));
    end
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.cell_count     = cell_r;
  assign out_ch.max_count      = max_r;
  assign out_ch.above_half_max = above_r;

  `HLA_ASSERT_IMP(a_no_accept_in_sweep, state_r == hla_pkg::ST_CLEAR, !in_ch.ready)
  `HLA_ASSERT_IMP(a_no_vote_write_on_read, state_r == hla_pkg::ST_READ, !ram_we)
  `HLA_ASSERT_IMP(a_wb_only_voting, wv_r, iss || state_r == hla_pkg::ST_DRAIN)
  `HLA_ASSERT_NXT(a_read_then_resp, state_r == hla_pkg::ST_READ, state_r == hla_pkg::ST_RESP)
endmodule
`default_nettype wire

@@ rtl/core/hla_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module hla_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [W-1:0]             rdata
);
  logic [W-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/hla_rho.sv @@
// Two-stage rho pipeline: trig products, then truncated rho and row check.
`default_nettype none
module hla_rho #(
  parameter int RHO_BINS = hla_pkg::RHO_BINS
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       iss,
  input  wire logic [hla_pkg::ANG_W-1:0]  ang,
  input  wire logic signed [10:0]         dx,
  input  wire logic signed [10:0]         dy,
  input  wire logic [9:0]                 ofs,
  output hla_pkg::hla_rho_st_t            st
);
  logic [hla_pkg::ANG_W-1:0] cdeg;
  logic [hla_pkg::ANG_W:0]   csum;
  logic signed [26:0]        pc_r, ps_r;
  logic                      v1_r, v2_r, ok2_r;
  logic [hla_pkg::ANG_W-1:0] a1_r, a2_r;
  logic [hla_pkg::ROW_W-1:0] row2_r;
  logic signed [27:0]        sum;
  logic [27:0]               mag;
  logic [13:0]               q;
  logic signed [15:0]        rho;
  logic signed [16:0]        row;

  always_comb begin
    csum = {1'b0, ang} + (hla_pkg::ANG_W+1)'(90);
    cdeg = (csum >= (hla_pkg::ANG_W+1)'(360)) ?
           hla_pkg::ANG_W'(csum - (hla_pkg::ANG_W+1)'(360)) : csum[hla_pkg::ANG_W-1:0];
  end

  always_ff @(posedge clk) begin
    pc_r <= dx * hla_pkg::hla_sin(cdeg);
    ps_r <= dy * hla_pkg::hla_sin(ang);
    a1_r <= ang;
  end

  // Truncate toward zero, then offset into a row.
  always_comb begin
    sum = 28'(pc_r) + 28'(ps_r);
    mag = sum[27] ? 28'(-sum) : 28'(sum);
    q   = mag[hla_pkg::TRIG_FRAC_BITS +: 14];
    rho = sum[27] ? -$signed({2'b0, q}) : $signed({2'b0, q});
    row = 17'(rho) + $signed({7'b0, ofs});
  end

  always_ff @(posedge clk) begin
    row2_r <= row[hla_pkg::ROW_W-1:0];
    ok2_r  <= !row[16] && (32'(row) < 32'(RHO_BINS));
    a2_r   <= a1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= iss;
      v2_r <= v1_r;
    end
  end

  assign st.busy = v1_r || v2_r;
  assign st.vld  = v2_r && ok2_r;
  assign st.row  = row2_r;
  assign st.ang  = a2_r;
endmodule
`default_nettype wire
